### design/windowed_score_accumulate_topk_defines.svh
// Assertion macros shared by the windowed score accumulator.
`ifndef WINDOWED_SCORE_ACCUMULATE_TOPK_DEFINES_SVH
`define WINDOWED_SCORE_ACCUMULATE_TOPK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/wsat_pkg.sv
// Package with types and constants of the windowed score accumulator.
package wsat_pkg;

  localparam int unsigned WindowSizeDefault    = 4096;
  localparam int unsigned MaxCandidatesDefault = 64;

  localparam int unsigned IdW    = 32;
  localparam int unsigned ScoreW = 40;
  localparam int unsigned WeightW = 16;
  localparam int unsigned LimitW = 7;

  localparam logic [LimitW-1:0] LimitReset = 7'd64;
  localparam logic [ScoreW-1:0] ScoreMax   = {ScoreW{1'b1}};

  typedef enum logic [1:0] {
    CMD_ACCUMULATE = 2'd0,
    CMD_SELECT     = 2'd1,
    CMD_DRAIN      = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_SHIFT  = 2'd2
  } cell_mode_e;

  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } acc_ctl_t;

endpackage

### design/wsat_cell.sv
// One candidate cell of the sorted store chain.
module wsat_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wsat_pkg::cell_mode_e           mode_i,
  input  logic [wsat_pkg::IdW-1:0]       new_id_i,
  input  logic [wsat_pkg::ScoreW-1:0]    new_score_i,
  input  logic                           prev_le_i,
  input  wsat_pkg::entry_t               prev_i,
  input  wsat_pkg::entry_t               next_i,
  output wsat_pkg::entry_t               entry_o,
  output logic                           le_o
);

  logic                        valid_q, valid_d;
  logic [wsat_pkg::IdW-1:0]    id_q, id_d;
  logic [wsat_pkg::ScoreW-1:0] score_q, score_d;

  assign le_o    = valid_q && (score_q <= new_score_i);
  assign entry_o = '{valid: valid_q, id: id_q, score: score_q};

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    score_d = score_q;
    unique case (mode_i)
      wsat_pkg::CM_INSERT: begin
        if (!le_o) begin
          if (prev_le_i) begin
            valid_d = 1'b1;
            id_d    = new_id_i;
            score_d = new_score_i;
          end else begin
            valid_d = prev_i.valid;
            id_d    = prev_i.id;
            score_d = prev_i.score;
          end
        end
      end
      wsat_pkg::CM_SHIFT: begin
        valid_d = next_i.valid;
        id_d    = next_i.id;
        score_d = next_i.score;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    score_q <= score_d;
  end

endmodule

### design/wsat_acc.sv
// Accumulator memory with a clearing pass after reset.
module wsat_acc #(
  parameter int unsigned WINDOW_SIZE = wsat_pkg::WindowSizeDefault,
  localparam int unsigned AddrW = $clog2(WINDOW_SIZE)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wsat_pkg::acc_ctl_t          ctl_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [wsat_pkg::ScoreW-1:0] wr_data_i,
  output logic [wsat_pkg::ScoreW-1:0] rd_data_o,
  output logic                        busy_o
);

  logic [wsat_pkg::ScoreW-1:0] mem [WINDOW_SIZE];
  logic [AddrW-1:0]            clr_q;
  logic                        busy_q;

  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AddrW'(WINDOW_SIZE - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

### design/windowed_score_accumulate_topk.sv
// Top level of the windowed score accumulator with a top-candidate store.
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_axis_tvalid/tready      command, doc id, weights
// m_axis    out        m_axis_tvalid/tready      candidate id, score, flag, last
// cfg       in         cfg_valid/cfg_ready       candidate limit
//
// Accumulate and select items finish in ST_ACC or ST_SEL; ignored items finish in idle.
// A select that lifts the count above the limit trims the lowest entries in ST_TRIM.
// A drain sends candidates lowest score first (one empty item if none), waiting on m_axis.
// After reset every memory word is cleared with s_axis held off.
// Configuration writes are taken in every cycle.
`include "windowed_score_accumulate_topk_defines.svh"

module windowed_score_accumulate_topk #(
  parameter int unsigned WINDOW_SIZE    = wsat_pkg::WindowSizeDefault,
  parameter int unsigned MAX_CANDIDATES = wsat_pkg::MaxCandidatesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // doc_id[31:0], posting_weight, query_weight
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // cand_doc_id[31:0], cand_score[71:32]
  output logic        m_axis_tuser,   // cand_valid
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data        // candidate_limit
);

  localparam int unsigned AddrW  = $clog2(WINDOW_SIZE);
  localparam int unsigned NCells = MAX_CANDIDATES + 1;
  localparam int unsigned CntW   = $clog2(MAX_CANDIDATES + 2);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_SEL   = 6'b001000,
    ST_TRIM  = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [wsat_pkg::LimitW-1:0] limit_q;
  logic [CntW-1:0]             lim;
  logic [CntW-1:0]             count_q, count_d;
  logic                        active_q, active_d;

  logic [wsat_pkg::IdW-1:0]    id_q;
  logic [AddrW-1:0]            slot_q;
  logic [31:0]                 prod_q;

  wsat_pkg::acc_ctl_t          acc_ctl;
  logic [wsat_pkg::ScoreW-1:0] acc_wdata;
  logic [wsat_pkg::ScoreW-1:0] acc_rdata;
  logic                        acc_busy;
  logic [wsat_pkg::ScoreW:0]   acc_sum;

  wsat_pkg::cell_mode_e        cell_mode;
  wsat_pkg::entry_t            cell_entry [NCells];
  logic                        cell_le [NCells];
  logic                        do_insert;

  logic                        out_valid_q;
  logic [wsat_pkg::IdW-1:0]    out_id_q;
  logic [wsat_pkg::ScoreW-1:0] out_score_q;
  logic                        out_flag_q;
  logic                        out_last_q;
  logic                        out_free;
  logic                        out_load;

  logic                        in_accept;
  wsat_pkg::cmd_e              in_cmd;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_cmd    = wsat_pkg::cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_score_q, out_id_q};
  assign m_axis_tuser  = out_flag_q;
  assign m_axis_tlast  = out_last_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    if (limit_q == '0) begin
      lim = CntW'(1);
    end else if (limit_q > wsat_pkg::LimitW'(MAX_CANDIDATES)) begin
      lim = CntW'(MAX_CANDIDATES);
    end else begin
      lim = CntW'(limit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wsat_pkg::LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      limit_q <= cfg_data;
    end
  end

  wsat_acc #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .rd_addr_i(s_axis_tdata[AddrW-1:0]),
    .wr_addr_i(slot_q),
    .wr_data_i(acc_wdata),
    .rd_data_o(acc_rdata),
    .busy_o   (acc_busy)
  );

  assign acc_sum = {1'b0, acc_rdata} + (wsat_pkg::ScoreW + 1)'(prod_q);

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    wsat_pkg::entry_t prev_e;
    wsat_pkg::entry_t next_e;
    logic             prev_le;
    if (g == 0) begin : g_first
      assign prev_e  = '0;
      assign prev_le = 1'b1;
    end else begin : g_mid
      assign prev_e  = cell_entry[g-1];
      assign prev_le = cell_le[g-1];
    end
    if (g == NCells - 1) begin : g_top
      assign next_e = '0;
    end else begin : g_below
      assign next_e = cell_entry[g+1];
    end
    wsat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .mode_i     (cell_mode),
      .new_id_i   (id_q),
      .new_score_i(acc_rdata),
      .prev_le_i  (prev_le),
      .prev_i     (prev_e),
      .next_i     (next_e),
      .entry_o    (cell_entry[g]),
      .le_o       (cell_le[g])
    );
  end

  assign do_insert = !active_q || (acc_rdata > cell_entry[0].score);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    active_d  = active_q;
    acc_ctl   = '0;
    acc_wdata = '0;
    cell_mode = wsat_pkg::CM_HOLD;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (!acc_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          acc_ctl.rd_en = 1'b1;
          unique case (in_cmd)
            wsat_pkg::CMD_ACCUMULATE: state_d = ST_ACC;
            wsat_pkg::CMD_SELECT:     state_d = ST_SEL;
            wsat_pkg::CMD_DRAIN: begin
              state_d  = ST_DRAIN;
              active_d = 1'b0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC: begin
        acc_ctl.wr_en = 1'b1;
        acc_wdata = acc_sum[wsat_pkg::ScoreW] ? wsat_pkg::ScoreMax
                                              : acc_sum[wsat_pkg::ScoreW-1:0];
        state_d = ST_IDLE;
      end
      ST_SEL: begin
        acc_ctl.wr_en = 1'b1;
        state_d = ST_IDLE;
        if (do_insert) begin
          cell_mode = wsat_pkg::CM_INSERT;
          count_d   = count_q + 1'b1;
          active_d  = 1'b1;
          if ((count_q + 1'b1) > lim) begin
            state_d = ST_TRIM;
          end
        end
      end
      ST_TRIM: begin
        cell_mode = wsat_pkg::CM_SHIFT;
        count_d   = count_q - 1'b1;
        if ((count_q - 1'b1) == lim) begin
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (count_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cell_mode = wsat_pkg::CM_SHIFT;
            count_d   = count_q - 1'b1;
            if (count_q == CntW'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      count_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      active_q <= active_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      id_q   <= s_axis_tdata[31:0];
      slot_q <= s_axis_tdata[AddrW-1:0];
      prod_q <= s_axis_tdata[47:32] * s_axis_tdata[63:48];
    end
    if (out_load) begin
      out_flag_q  <= (count_q != '0);
      out_last_q  <= (count_q == '0) || (count_q == CntW'(1));
      out_id_q    <= (count_q == '0) ? '0 : cell_entry[0].id;
      out_score_q <= (count_q == '0) ? '0 : cell_entry[0].score;
    end
  end

  `WSAT_ASSERT_NOW(a_trim_above_limit, clk_i, rst_ni, state_q == ST_TRIM, count_q > lim)
  `WSAT_ASSERT_NOW(a_idle_count_bound, clk_i, rst_ni, state_q == ST_IDLE,
                   count_q <= CntW'(MAX_CANDIDATES))
  `WSAT_ASSERT_NOW(a_clear_blocks_input, clk_i, rst_ni, acc_busy, !s_axis_tready)
  `WSAT_ASSERT_NEXT(a_select_next, clk_i, rst_ni,
                    in_accept && in_cmd == wsat_pkg::CMD_SELECT, state_q == ST_SEL)

endmodule
